[src/soundex_encoder_unit_macros.svh]
// Assertion macros shared by the soundex encoder RTL.
// Used by sdx_queue and sdx_back; needs signals clk and arst_n in scope.
`ifndef SOUNDEX_ENCODER_UNIT_MACROS_SVH
`define SOUNDEX_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check on every clock edge out of reset
`define SDX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check on every clock edge, reset included
`define SDX_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SDX_ASSERT(label, prop, msg)
`define SDX_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[src/sdx_pkg.sv]
// Shared types, symbol constants and the letter-to-digit table of the soundex encoder.
// No dependencies.
package sdx_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CODE_LEN = 4;

	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_ONE   = 8'h31;
	localparam logic [7:0] SYM_TWO   = 8'h32;
	localparam logic [7:0] SYM_THREE = 8'h33;
	localparam logic [7:0] SYM_FOUR  = 8'h34;
	localparam logic [7:0] SYM_FIVE  = 8'h35;
	localparam logic [7:0] SYM_SIX   = 8'h36;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
	} sdx_item_t;

	function automatic logic [7:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		unique case (c) inside
			" ", "A", "E", "H", "I", "O", "U", "W", "Y": d = SYM_ZERO;
			"B", "F", "P", "V":                          d = SYM_ONE;
			"C", "G", "J", "K", "Q", "S", "X", "Z":      d = SYM_TWO;
			"D", "T":                                    d = SYM_THREE;
			"L":                                         d = SYM_FOUR;
			"M", "N":                                    d = SYM_FIVE;
			"R":                                         d = SYM_SIX;
			default:                                     d = c;
		endcase
		return d;
	endfunction

endpackage

[src/soundex_encoder_unit.sv]
// Top level of the soundex encoder: front end, request queue and back end.
// Depends on sdx_pkg, sdx_front, sdx_queue and sdx_back.
//
// Takes one character per clock cycle while in_stall is low; a request carries the
// word_end flag on the last character of a word, and that request yields the
// four-symbol code. An accepted character is mapped combinationally and queued; the
// back end pops it, and a word's code is registered when its word end is popped. The
// sustained rate of one character per cycle is set by the combinational symbol map
// in the front end and the compare with the last kept symbol in the back end. While
// the output register is held by out_stall, characters keep flowing until the next
// word end reaches the back end; that word end and at most QUEUE_DEPTH - 1 further
// characters wait in the queue before in_stall rises.
module soundex_encoder_unit import sdx_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_in,
	input  logic       word_end,
	input  logic       in_valid,
	output logic       in_stall,
	output logic [7:0] code_char0,
	output logic [7:0] code_char1,
	output logic [7:0] code_char2,
	output logic [7:0] code_char3,
	output logic       out_valid,
	input  logic       out_stall
);

	sdx_item_t push_item;
	sdx_item_t pop_item;
	logic      push;
	logic      pop;
	logic      queue_full;
	logic      pop_valid;

	sdx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.word_end   (word_end),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	sdx_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_item  (pop_item)
	);

	sdx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop),
		.code_char0 (code_char0),
		.code_char1 (code_char1),
		.code_char2 (code_char2),
		.code_char3 (code_char3),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule

[src/sdx_front.sv]
// Front end: accepts characters, folds case and maps all but the first of each word to symbols.
// Depends on sdx_pkg.
module sdx_front import sdx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_in,
	input  logic       word_end,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       queue_full,
	output logic       push,
	output sdx_item_t  push_item
);

	logic       at_start_q;
	logic [7:0] folded;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		folded = char_in;
		if (char_in >= "a" && char_in <= "z") begin
			folded = char_in - CASE_GAP;
		end
		push_item.sym  = at_start_q ? folded : digit_of(folded);
		push_item.last = word_end;
	end

	// the character after a word end opens a new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
		end else if (push) begin
			at_start_q <= word_end;
		end
	end

endmodule

[src/sdx_queue.sv]
// Short request queue between the front and back ends.
// Depends on sdx_pkg and the assertion macros.
`include "soundex_encoder_unit_macros.svh"
module sdx_queue import sdx_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sdx_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      pop_valid,
	output sdx_item_t pop_item
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sdx_item_t         entries_q [DEPTH];
	logic [IW-1:0]     wr_q;
	logic [IW-1:0]     rd_q;
	logic [CW-1:0]     count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`SDX_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "queue count beyond depth")
	`SDX_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> count_q == '0, "queue not empty after reset")
	`SDX_ASSERT(a_count_up, push && !pop |=> count_q == $past(count_q) + 1'b1, "queue lost a push")
	`SDX_ASSERT(a_pop_nonempty, pop |-> pop_valid, "pop from empty queue")

endmodule

[src/sdx_back.sv]
// Back end: drops zeros and repeats, collects up to four symbols, registers the code.
// Depends on sdx_pkg and the assertion macros.
`include "soundex_encoder_unit_macros.svh"
module sdx_back import sdx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	input  sdx_item_t  pop_item,
	output logic       pop,
	output logic [7:0] code_char0,
	output logic [7:0] code_char1,
	output logic [7:0] code_char2,
	output logic [7:0] code_char3,
	output logic       out_valid,
	input  logic       out_stall
);

	logic [2:0] kept_q;
	logic [7:0] last_kept_q;
	logic [7:0] buf_q [CODE_LEN];
	logic [7:0] code_q [CODE_LEN];
	logic       out_valid_q;

	logic [7:0] buf_nxt [CODE_LEN];
	logic [2:0] kept_nxt;
	logic       keep;

	// a word end waits until the output register is free
	assign pop = pop_valid && (!pop_item.last || !out_valid_q || !out_stall);

	always_comb begin
		keep = (pop_item.sym != SYM_ZERO) && (pop_item.sym != last_kept_q)
			&& (kept_q < 3'(CODE_LEN));
		buf_nxt  = buf_q;
		kept_nxt = kept_q;
		if (keep) begin
			buf_nxt[kept_q[1:0]] = pop_item.sym;
			kept_nxt = kept_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q      <= '0;
			last_kept_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CODE_LEN; i++) begin
				buf_q[i] <= SYM_ZERO;
			end
		end else begin
			if (pop && pop_item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (pop_item.last) begin
					kept_q      <= '0;
					last_kept_q <= '0;
					for (int i = 0; i < CODE_LEN; i++) begin
						buf_q[i] <= SYM_ZERO;
					end
				end else begin
					kept_q <= kept_nxt;
					buf_q  <= buf_nxt;
					if (pop_item.sym != SYM_ZERO) begin
						last_kept_q <= pop_item.sym;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.last) begin
			code_q <= buf_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_char0 = code_q[0];
	assign code_char1 = code_q[1];
	assign code_char2 = code_q[2];
	assign code_char3 = code_q[3];

	`SDX_ASSERT(a_kept_bound, kept_q <= 3'(CODE_LEN), "kept count beyond code length")
	`SDX_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid_q, "code valid after reset")
	`SDX_ASSERT(a_pad_tail, kept_q < 3'(CODE_LEN) |-> buf_q[CODE_LEN-1] == SYM_ZERO, "tail not padded")
	`SDX_ASSERT(a_word_clear, pop && pop_item.last |=> kept_q == '0 && last_kept_q == '0, "word state not cleared")

endmodule
